// ===== rtl/tct_pkg.sv =====
// shared types, register codes and constants of the three channel timer
package tct_pkg;

	localparam int CYCLE_W          = 32;
	localparam int CNT_W            = 16;
	localparam int NUM_TIMERS       = 3;
	localparam int E_DIVIDE_DEFAULT = 10;

	// bus commands
	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	// register addresses below the counter block
	localparam logic [2:0] ADDR_CTRL_1_3 = 3'd0;
	localparam logic [2:0] ADDR_CTRL_2   = 3'd1;

	// control and status bit positions
	localparam int CR_HOLD_BIT    = 0;
	localparam int CR_DIV8_BIT    = 1;
	localparam int CR_IRQ_EN_BIT  = 6;
	localparam int STATUS_ANY_BIT = 7;

	localparam logic [7:0] CTRL_RESET = 8'h01;

	typedef struct packed {
		logic [1:0]         command;
		logic [2:0]         reg_addr;
		logic [7:0]         write_data;
		logic [CYCLE_W-1:0] cycle_count;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq;
	} result_t;

endpackage

// ===== rtl/tct_edivide.sv =====
// constant divide of the tick cycle count by reciprocal multiply, registered
module tct_edivide #(
	parameter int E_DIVIDE = tct_pkg::E_DIVIDE_DEFAULT
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [tct_pkg::CYCLE_W-1:0] cycles,
	output logic [tct_pkg::CYCLE_W-1:0] quotient_s2
);
	import tct_pkg::*;

	// floor(x / E) = (x * ceil(2^SHIFT / E)) >> SHIFT for all x below 2^CYCLE_W
	localparam int SHIFT = CYCLE_W + $clog2(E_DIVIDE);
	localparam int PROD_W = CYCLE_W + SHIFT;
	localparam logic [PROD_W-1:0] ONE_SHIFTED = PROD_W'(1) << SHIFT;
	localparam logic [PROD_W-1:0] RECIP_W =
		(ONE_SHIFTED + PROD_W'(E_DIVIDE - 1)) / PROD_W'(E_DIVIDE);
	localparam logic [CYCLE_W:0] RECIP = RECIP_W[CYCLE_W:0];

	logic [PROD_W-1:0] product;

	assign product = PROD_W'(cycles) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			quotient_s2 <= CYCLE_W'(product >> SHIFT);
		end
	end

endmodule

// ===== rtl/three_channel_timer_module.sv =====
// top level of the three channel 16-bit timer: pipeline, bus registers and counters
//
//   channel   direction  handshake             payload
//   item      in         item_valid/stall      item_t: command, reg_addr, write_data, cycle_count
//   result    out        result_valid/stall    result_t: read_data, irq
//   cfg       in         cfg_valid/ready       cfg_data: legacy_divide
//
// one transaction enters per cycle while item_stall is low; each result passes three registers
// after its item (input register, divide register, result register).
// the cycle-count multiply sits in its own stage; all register and counter updates
// happen in the last stage, in item order, so back to back items see each other.
// reset puts every timer register at its power-on value at once, no clearing pass.
// a stalled result holds the pipe; item_stall rises only while every stage is full.
module three_channel_timer_module #(
	parameter int E_DIVIDE = tct_pkg::E_DIVIDE_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  tct_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output tct_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_data
);
	import tct_pkg::*;

	// pipeline control
	logic    valid_s1, valid_s2;
	item_t   item_s1, item_s2;
	logic [CYCLE_W-1:0] quot_s2;
	logic    adv_s1, adv_s2;

	// architectural state
	logic [7:0]       ctrl_q   [NUM_TIMERS];
	logic             sel_first_q;
	logic [7:0]       status_q;
	logic [CNT_W-1:0] cnt_q    [NUM_TIMERS];
	logic [CNT_W-1:0] latch_q  [NUM_TIMERS];
	logic [7:0]       hold_q   [NUM_TIMERS];
	logic [7:0]       hbuf_q;
	logic             legacy_q;

	logic [7:0]       ctrl_d   [NUM_TIMERS];
	logic             sel_first_d;
	logic [7:0]       status_d;
	logic [CNT_W-1:0] cnt_d    [NUM_TIMERS];
	logic [CNT_W-1:0] latch_d  [NUM_TIMERS];
	logic [7:0]       hold_d   [NUM_TIMERS];
	logic [7:0]       hbuf_d;
	logic [7:0]       rd_d;
	logic             irq_d;

	assign cfg_ready = 1'b1;

	assign adv_s2     = valid_s2 && (!result_valid || !result_stall);
	assign adv_s1     = valid_s1 && (!valid_s2 || adv_s2);
	assign item_stall = valid_s1 && valid_s2 && !adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (!item_stall) begin
				valid_s1 <= item_valid;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (adv_s2) begin
				valid_s2 <= 1'b0;
			end
			if (adv_s2) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
		if (adv_s1) begin
			item_s2 <= item_s1;
		end
		if (adv_s2) begin
			result.read_data <= rd_d;
			result.irq       <= irq_d;
		end
	end

	tct_edivide #(
		.E_DIVIDE(E_DIVIDE)
	) u_edivide (
		.clk        (clk),
		.en         (adv_s1),
		.cycles     (item_s1.cycle_count),
		.quotient_s2(quot_s2)
	);

	// bus access and tick on the item in the last stage
	always_comb begin
		logic [1:0]         tsel;
		logic [CYCLE_W-1:0] dec;

		ctrl_d      = ctrl_q;
		sel_first_d = sel_first_q;
		status_d    = status_q;
		cnt_d       = cnt_q;
		latch_d     = latch_q;
		hold_d      = hold_q;
		hbuf_d      = hbuf_q;
		rd_d        = 8'h00;
		dec         = '0;
		// addresses 2..7 map pairwise onto timers 0..2
		tsel        = item_s2.reg_addr[2:1] - 2'd1;

		case (item_s2.command)
			CMD_READ: begin
				if (item_s2.reg_addr == ADDR_CTRL_2) begin
					rd_d = status_q;
				end else if (item_s2.reg_addr != ADDR_CTRL_1_3) begin
					if (!item_s2.reg_addr[0]) begin
						hold_d[tsel]   = cnt_q[tsel][7:0];
						status_d[tsel] = 1'b0;
						if (status_d[2:0] == 3'b000) begin
							status_d[STATUS_ANY_BIT] = 1'b0;
						end
						rd_d = cnt_q[tsel][15:8];
					end else begin
						rd_d = hold_q[tsel];
					end
				end
			end
			CMD_WRITE: begin
				if (item_s2.reg_addr == ADDR_CTRL_1_3) begin
					if (sel_first_q) begin
						ctrl_d[0] = item_s2.write_data;
						if (item_s2.write_data[CR_HOLD_BIT]) begin
							status_d = 8'h00;
						end
					end else begin
						ctrl_d[2] = item_s2.write_data;
					end
				end else if (item_s2.reg_addr == ADDR_CTRL_2) begin
					ctrl_d[1]   = item_s2.write_data;
					sel_first_d = item_s2.write_data[0];
				end else if (!item_s2.reg_addr[0]) begin
					hbuf_d = item_s2.write_data;
				end else begin
					latch_d[tsel] = {hbuf_q, item_s2.write_data};
					cnt_d[tsel]   = {hbuf_q, item_s2.write_data};
				end
			end
			CMD_TICK: begin
				if (!ctrl_q[0][CR_HOLD_BIT]) begin
					for (int i = 0; i < NUM_TIMERS; i++) begin
						if (legacy_q) begin
							dec = ctrl_q[i][CR_DIV8_BIT] ? (item_s2.cycle_count >> 3)
							                             : item_s2.cycle_count;
						end else begin
							dec = (i == 2 && ctrl_q[2][CR_HOLD_BIT]) ? (quot_s2 >> 3)
							                                         : quot_s2;
						end
						if (CYCLE_W'(cnt_q[i]) >= dec) begin
							cnt_d[i] = cnt_q[i] - dec[CNT_W-1:0];
						end else begin
							status_d[i]              = 1'b1;
							status_d[STATUS_ANY_BIT] = 1'b1;
							cnt_d[i]                 = latch_q[i];
						end
					end
				end
			end
			default: begin
			end
		endcase

		irq_d = 1'b0;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			if (status_d[i] && ctrl_d[i][CR_IRQ_EN_BIT]) begin
				irq_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TIMERS; i++) begin
				ctrl_q[i]  <= CTRL_RESET;
				cnt_q[i]   <= '0;
				latch_q[i] <= '0;
				hold_q[i]  <= '0;
			end
			sel_first_q <= 1'b1;
			status_q    <= '0;
			hbuf_q      <= '0;
			legacy_q    <= 1'b0;
		end else begin
			if (adv_s2) begin
				ctrl_q      <= ctrl_d;
				sel_first_q <= sel_first_d;
				status_q    <= status_d;
				cnt_q       <= cnt_d;
				latch_q     <= latch_d;
				hold_q      <= hold_d;
				hbuf_q      <= hbuf_d;
			end
			if (cfg_valid && cfg_ready) begin
				legacy_q <= cfg_data;
			end
		end
	end

endmodule

// ===== tb/sv/three_channel_timer_module_tb.sv =====
// testbench of the three channel timer: directed table, random transactions, scoreboard
`timescale 1ns / 1ps

module three_channel_timer_module_tb;
	import tct_pkg::*;

	localparam logic [1:0] CMD_UNUSED  = 2'd3;
	localparam logic [2:0] ADDR_T1_MSB = 3'd2;
	localparam logic [2:0] ADDR_T1_LSB = 3'd3;
	localparam logic [2:0] ADDR_T2_MSB = 3'd4;
	localparam logic [2:0] ADDR_T2_LSB = 3'd5;
	localparam logic [2:0] ADDR_T3_MSB = 3'd6;
	localparam logic [2:0] ADDR_T3_LSB = 3'd7;
	localparam int unsigned TIMER_E_DIV = E_DIVIDE_DEFAULT;
	localparam int LONG_HOLD_CYCLES = 80;

	typedef struct {
		item_t   it;
		bit      fixed;
		result_t res;
	} row_t;

	logic    clk;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;
	logic    cfg_valid = 1'b0;
	logic    cfg_ready;
	logic    cfg_data = 1'b0;

	// shadow of the timer state
	logic [7:0]  sh_ctrl [3];
	logic        sh_sel_first;
	logic [7:0]  sh_status;
	logic [15:0] sh_count [3];
	logic [15:0] sh_latch [3];
	logic [7:0]  sh_low_hold [3];
	logic [7:0]  sh_msb_buf;
	logic        sh_legacy;

	result_t pending_results[$];
	row_t    directed_rows[$];
	int      err_count = 0;
	int      sent_count = 0;
	bit      no_idle = 1'b0;
	bit      long_hold = 1'b0;

	three_channel_timer_module dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("three_channel_timer_module_tb: FAIL");
		$finish;
	end

	task automatic shadow_reset();
		for (int t = 0; t < NUM_TIMERS; t++) begin
			sh_ctrl[t] = CTRL_RESET;
			sh_count[t] = '0;
			sh_latch[t] = '0;
			sh_low_hold[t] = '0;
		end
		sh_sel_first = 1'b1;
		sh_status = '0;
		sh_msb_buf = '0;
		sh_legacy = 1'b0;
	endtask

	function automatic result_t timer_predict(item_t it);
		result_t r;
		int t;
		logic [31:0] dec;
		r = '0;
		t = (int'(it.reg_addr) - 2) >>> 1;
		case (it.command)
			CMD_READ: begin
				if (it.reg_addr == ADDR_CTRL_1_3) begin
					r.read_data = '0;
				end else if (it.reg_addr == ADDR_CTRL_2) begin
					r.read_data = sh_status;
				end else if (!it.reg_addr[0]) begin
					// msb read captures the lsb and acknowledges that timer's flag
					sh_low_hold[t] = sh_count[t][7:0];
					sh_status[t] = 1'b0;
					if (sh_status[2:0] == 3'b000) sh_status[STATUS_ANY_BIT] = 1'b0;
					r.read_data = sh_count[t][15:8];
				end else begin
					r.read_data = sh_low_hold[t];
				end
			end
			CMD_WRITE: begin
				if (it.reg_addr == ADDR_CTRL_1_3) begin
					if (sh_sel_first) begin
						sh_ctrl[0] = it.write_data;
						if (it.write_data[CR_HOLD_BIT]) sh_status = '0;
					end else begin
						sh_ctrl[2] = it.write_data;
					end
				end else if (it.reg_addr == ADDR_CTRL_2) begin
					sh_ctrl[1] = it.write_data;
					sh_sel_first = it.write_data[0];
				end else if (!it.reg_addr[0]) begin
					sh_msb_buf = it.write_data;
				end else begin
					sh_latch[t] = {sh_msb_buf, it.write_data};
					sh_count[t] = sh_latch[t];
				end
			end
			CMD_TICK: begin
				if (!sh_ctrl[0][CR_HOLD_BIT]) begin
					for (int k = 0; k < NUM_TIMERS; k++) begin
						dec = it.cycle_count;
						if (sh_legacy) begin
							if (sh_ctrl[k][CR_DIV8_BIT]) dec = dec / 8;
						end else begin
							dec = dec / TIMER_E_DIV;
							if (k == 2 && sh_ctrl[2][0]) dec = dec / 8;
						end
						if ({16'd0, sh_count[k]} >= dec) begin
							sh_count[k] = sh_count[k] - dec[15:0];
						end else begin
							sh_status[k] = 1'b1;
							sh_status[STATUS_ANY_BIT] = 1'b1;
							sh_count[k] = sh_latch[k];
						end
					end
				end
			end
			default: ;
		endcase
		r.irq = 1'b0;
		for (int k = 0; k < NUM_TIMERS; k++)
			if (sh_status[k] && sh_ctrl[k][CR_IRQ_EN_BIT]) r.irq = 1'b1;
		return r;
	endfunction

	// offer one transaction; the expectation is recorded when it is accepted
	task automatic offer_item(item_t it, bit fixed, result_t fixed_res);
		int gap;
		result_t predicted;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		predicted = timer_predict(it);
		pending_results.push_back(fixed ? fixed_res : predicted);
		sent_count++;
	endtask

	task automatic drain_block();
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_divide_mode(logic mode);
		drain_block();
		cfg_valid <= 1'b1;
		cfg_data <= mode;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sh_legacy = mode;
	endtask

	function automatic item_t rand_item();
		item_t it;
		it.command = 2'($urandom_range(0, 3));
		it.reg_addr = 3'($urandom_range(0, 7));
		it.write_data = 8'($urandom_range(0, 255));
		it.cycle_count = $urandom;
		return it;
	endfunction

	task automatic add_row(logic [1:0] cmd, logic [2:0] addr, logic [7:0] data,
			logic [31:0] cycles, bit fixed, logic [7:0] rd, logic irq);
		row_t r;
		r.it = '{command: cmd, reg_addr: addr, write_data: data, cycle_count: cycles};
		r.fixed = fixed;
		r.res = '{read_data: rd, irq: irq};
		directed_rows.push_back(r);
	endtask

	task automatic random_episode();
		item_t a, b;
		int unsigned kind, t, sel;
		kind = $urandom_range(0, 99);
		a = rand_item();
		b = rand_item();
		t = $urandom_range(0, 2);
		if ($urandom_range(0, 39) == 0) no_idle = ~no_idle;
		if (kind < 20) begin
			// reload a timer: msb into the buffer, then lsb loads latch and counter
			a.command = CMD_WRITE;
			a.reg_addr = ADDR_T1_MSB + 3'(2 * t);
			if ($urandom_range(0, 3) != 0) a.write_data = 8'($urandom_range(0, 1));
			b.command = CMD_WRITE;
			b.reg_addr = ADDR_T1_LSB + 3'(2 * t);
			offer_item(a, 1'b0, '0);
			offer_item(b, 1'b0, '0);
		end else if (kind < 40) begin
			a.command = CMD_READ;
			a.reg_addr = ADDR_T1_MSB + 3'(2 * t);
			b.command = CMD_READ;
			b.reg_addr = ADDR_T1_LSB + 3'(2 * t);
			offer_item(a, 1'b0, '0);
			offer_item(b, 1'b0, '0);
		end else if (kind < 65) begin
			a.command = CMD_TICK;
			sel = $urandom_range(0, 9);
			if (sel < 3) a.cycle_count = $urandom_range(0, 15);
			else if (sel < 8) a.cycle_count = $urandom_range(0, 4000);
			offer_item(a, 1'b0, '0);
		end else if (kind < 77) begin
			a.command = CMD_WRITE;
			a.reg_addr = ADDR_CTRL_2;
			b.command = CMD_WRITE;
			b.reg_addr = ADDR_CTRL_1_3;
			// mostly leave the timers running
			if ($urandom_range(0, 4) != 0) b.write_data[CR_HOLD_BIT] = 1'b0;
			offer_item(a, 1'b0, '0);
			offer_item(b, 1'b0, '0);
		end else if (kind < 87) begin
			a.command = CMD_READ;
			a.reg_addr = ADDR_CTRL_2;
			offer_item(a, 1'b0, '0);
		end else begin
			offer_item(a, 1'b0, '0);
		end
	endtask

	task automatic random_phase(int n);
		int target;
		target = sent_count + n;
		while (sent_count < target) random_episode();
	endtask

	// result side: random stall before each transaction, one long hold on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				result_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
			end else begin
				n = no_idle ? 0 : $urandom_range(0, 10);
				if (n > 0) begin
					result_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				if (err_count < 10)
					$display("unexpected result: read_data %02h irq %0b",
						result.read_data, result.irq);
				err_count++;
			end else begin
				want = pending_results.pop_front();
				if (result.read_data !== want.read_data || result.irq !== want.irq) begin
					if (err_count < 10)
						$display("mismatch: read_data exp %02h got %02h, irq exp %0b got %0b",
							want.read_data, result.read_data, want.irq, result.irq);
					err_count++;
				end
			end
		end
	end

	initial begin
		shadow_reset();
		// after reset, timers held
		add_row(CMD_READ,   ADDR_CTRL_2,   8'h00, 32'h0,        1'b1, 8'h00, 1'b0);
		add_row(CMD_READ,   ADDR_CTRL_1_3, 8'hFF, 32'hFFFFFFFF, 1'b1, 8'h00, 1'b0);
		add_row(CMD_READ,   ADDR_T1_MSB,   8'h00, 32'h0,        1'b1, 8'h00, 1'b0);
		add_row(CMD_READ,   ADDR_T3_LSB,   8'h00, 32'h0,        1'b1, 8'h00, 1'b0);
		add_row(CMD_UNUSED, ADDR_T2_LSB,   8'hFF, 32'hFFFFFFFF, 1'b1, 8'h00, 1'b0);
		add_row(CMD_TICK,   ADDR_CTRL_1_3, 8'h00, 32'hFFFFFFFF, 1'b1, 8'h00, 1'b0);
		add_row(CMD_WRITE,  ADDR_CTRL_2,   8'h01, 32'h0,        1'b1, 8'h00, 1'b0);
		add_row(CMD_WRITE,  ADDR_CTRL_1_3, 8'h40, 32'h0,        1'b1, 8'h00, 1'b0);
		add_row(CMD_WRITE,  ADDR_T1_MSB,   8'h00, 32'h0,        1'b0, 8'h00, 1'b0);
		add_row(CMD_WRITE,  ADDR_T1_LSB,   8'h05, 32'h0,        1'b0, 8'h00, 1'b0);
		add_row(CMD_WRITE,  ADDR_T2_MSB,   8'hFF, 32'h0,        1'b0, 8'h00, 1'b0);
		add_row(CMD_WRITE,  ADDR_T2_LSB,   8'hFF, 32'h0,        1'b0, 8'h00, 1'b0);
		add_row(CMD_WRITE,  ADDR_T3_MSB,   8'h00, 32'h0,        1'b0, 8'h00, 1'b0);
		add_row(CMD_WRITE,  ADDR_T3_LSB,   8'h00, 32'h0,        1'b0, 8'h00, 1'b0);
		add_row(CMD_TICK,   ADDR_CTRL_1_3, 8'h00, 32'd0,        1'b0, 8'h00, 1'b0);
		add_row(CMD_TICK,   ADDR_CTRL_1_3, 8'h00, 32'd50,       1'b0, 8'h00, 1'b0);
		add_row(CMD_TICK,   ADDR_CTRL_1_3, 8'h00, 32'd10,       1'b0, 8'h00, 1'b0);
		add_row(CMD_READ,   ADDR_CTRL_2,   8'h00, 32'h0,        1'b0, 8'h00, 1'b0);
		add_row(CMD_READ,   ADDR_T1_MSB,   8'h00, 32'h0,        1'b0, 8'h00, 1'b0);
		add_row(CMD_READ,   ADDR_T1_LSB,   8'h00, 32'h0,        1'b0, 8'h00, 1'b0);
		add_row(CMD_WRITE,  ADDR_CTRL_2,   8'h00, 32'h0,        1'b0, 8'h00, 1'b0);
		add_row(CMD_WRITE,  ADDR_CTRL_1_3, 8'hFF, 32'h0,        1'b0, 8'h00, 1'b0);
		add_row(CMD_TICK,   ADDR_CTRL_1_3, 8'h00, 32'hFFFFFFFF, 1'b0, 8'h00, 1'b0);
		add_row(CMD_READ,   ADDR_T3_MSB,   8'h00, 32'h0,        1'b0, 8'h00, 1'b0);
		add_row(CMD_READ,   ADDR_T3_LSB,   8'h00, 32'h0,        1'b0, 8'h00, 1'b0);
		add_row(CMD_WRITE,  ADDR_CTRL_2,   8'hFF, 32'h0,        1'b0, 8'h00, 1'b0);
		// hold bit clears every flag, so the line drops
		add_row(CMD_WRITE,  ADDR_CTRL_1_3, 8'h01, 32'h0,        1'b1, 8'h00, 1'b0);
		add_row(CMD_TICK,   ADDR_CTRL_1_3, 8'h00, 32'd1000,     1'b0, 8'h00, 1'b0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_divide_mode(1'b0);
		foreach (directed_rows[i])
			offer_item(directed_rows[i].it, directed_rows[i].fixed, directed_rows[i].res);

		// back-pressure: receiver holds off while transactions keep coming
		drain_block();
		long_hold = 1'b1;
		no_idle = 1'b1;
		random_phase(30);
		no_idle = 1'b0;
		random_phase(170);

		write_divide_mode(1'b1);
		random_phase(200);
		write_divide_mode(1'b0);
		random_phase(150);
		write_divide_mode(1'b1);
		random_phase(200);

		drain_block();
		if (err_count == 0 && pending_results.size() == 0) begin
			$display("three_channel_timer_module_tb: PASS");
		end else begin
			$display("three_channel_timer_module_tb: FAIL");
		end
		$finish;
	end

endmodule
